>>> sv/ntt_pkg.sv
// ntt_pkg: shared types and constants of the nearest target tracker.
// Holds the register map, the configuration widths and the configuration bundle.
// No dependencies.
package ntt_pkg;

    // APB register map
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_GATE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PERSIST = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOST    = 2'd2;

    // Register widths and reset values
    localparam int GATE_W    = 16;
    localparam int GATE_SQ_W = 2 * GATE_W;
    localparam int LIMIT_W   = 8;

    localparam logic [GATE_W-1:0]  GATE_RESET    = 16'd1920;
    localparam logic [LIMIT_W-1:0] PERSIST_RESET = 8'd3;
    localparam logic [LIMIT_W-1:0] LOST_RESET    = 8'd10;

    // Configuration as seen by the tracking core
    typedef struct packed {
        logic [GATE_W-1:0]    gate;
        logic [GATE_SQ_W-1:0] gate_sq;
        logic [LIMIT_W-1:0]   persist_limit;
        logic [LIMIT_W-1:0]   lost_limit;
    } t_cfg;

endpackage

>>> sv/ntt_cfg.sv
// ntt_cfg: APB register block of the nearest target tracker.
// Holds gate distance, persistence and lost limits, and the registered gate square.
// Depends on ntt_pkg.
module ntt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ntt_pkg::PADDR_W-1:0]   paddr,
    input  logic [ntt_pkg::PDATA_W-1:0]   pwdata,
    output logic [ntt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output ntt_pkg::t_cfg                 o_cfg
);

    logic [ntt_pkg::GATE_W-1:0]    r_gate;
    logic [ntt_pkg::GATE_SQ_W-1:0] r_gate_sq;
    logic [ntt_pkg::LIMIT_W-1:0]   r_persist;
    logic [ntt_pkg::LIMIT_W-1:0]   r_lost;
    logic                          wr_en;
    logic [ntt_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ntt_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate    <= ntt_pkg::GATE_RESET;
            r_persist <= ntt_pkg::PERSIST_RESET;
            r_lost    <= ntt_pkg::LOST_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                ntt_pkg::REG_GATE:    r_gate    <= pwdata[ntt_pkg::GATE_W-1:0];
                ntt_pkg::REG_PERSIST: r_persist <= pwdata[ntt_pkg::LIMIT_W-1:0];
                ntt_pkg::REG_LOST:    r_lost    <= pwdata[ntt_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Square the gate once per cycle; the user writes only while idle (unenforced)
    always_ff @(posedge i_clk) begin
        r_gate_sq <= ntt_pkg::GATE_SQ_W'(r_gate) * ntt_pkg::GATE_SQ_W'(r_gate);
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            ntt_pkg::REG_GATE:    prdata = ntt_pkg::PDATA_W'(r_gate);
            ntt_pkg::REG_PERSIST: prdata = ntt_pkg::PDATA_W'(r_persist);
            ntt_pkg::REG_LOST:    prdata = ntt_pkg::PDATA_W'(r_lost);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.gate          = r_gate;
    assign o_cfg.gate_sq       = r_gate_sq;
    assign o_cfg.persist_limit = r_persist;
    assign o_cfg.lost_limit    = r_lost;

endmodule

>>> sv/ntt_dist.sv
// ntt_dist: squared Euclidean distance from a candidate to the tracked center.
// Two parallel squarers and one adder, exact result.
// No dependencies.
module ntt_dist #(
    parameter int COORD_BITS = 16,
    localparam int DIST_W    = 2 * COORD_BITS + 1
) (
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [COORD_BITS-1:0] i_track_x,
    input  logic [COORD_BITS-1:0] i_track_y,
    output logic [DIST_W-1:0]     o_dist_sq
);

    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] dx_sq;
    logic [2*COORD_BITS-1:0] dy_sq;

    assign dx    = (i_x >= i_track_x) ? i_x - i_track_x : i_track_x - i_x;
    assign dy    = (i_y >= i_track_y) ? i_y - i_track_y : i_track_y - i_y;
    assign dx_sq = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
    assign dy_sq = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
    assign o_dist_sq = DIST_W'(dx_sq) + DIST_W'(dy_sq);

endmodule

>>> sv/ntt_core.sv
// ntt_core: track state, per-frame nearest search and result register.
// Consumes one buffered candidate per cycle and its distance from ntt_dist; a frame end stalls while a result waits.
// Depends on ntt_pkg.
module ntt_core #(
    parameter int MAX_CANDIDATES = 64,
    parameter int COORD_BITS     = 16,
    parameter int COUNT_BITS     = 8,
    localparam int IDX_W         = $clog2(MAX_CANDIDATES),
    localparam int SLOT_W        = $clog2(MAX_CANDIDATES + 1),
    localparam int DIST_W        = 2 * COORD_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ntt_pkg::t_cfg         i_cfg,
    input  logic                  i_item_valid,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  logic                  i_frame_empty,
    input  logic                  i_last_of_frame,
    input  logic [DIST_W-1:0]     i_dist_sq,
    output logic                  o_advance,
    output logic [COORD_BITS-1:0] o_track_x,
    output logic [COORD_BITS-1:0] o_track_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_target_valid,
    output logic [IDX_W-1:0]      o_chosen_index,
    output logic [COORD_BITS-1:0] o_chosen_x,
    output logic [COORD_BITS-1:0] o_chosen_y,
    output logic [COUNT_BITS-1:0] o_stable_count,
    output logic [COUNT_BITS-1:0] o_lost_count,
    output logic                  o_overflow_flag
);

    localparam int CMP_W  = (DIST_W > ntt_pkg::GATE_SQ_W) ? DIST_W : ntt_pkg::GATE_SQ_W;
    localparam int LCMP_W = (COUNT_BITS > ntt_pkg::LIMIT_W) ? COUNT_BITS : ntt_pkg::LIMIT_W;

    // Track and frame state
    logic                  r_active,  n_active;
    logic [COORD_BITS-1:0] r_track_x, n_track_x;
    logic [COORD_BITS-1:0] r_track_y, n_track_y;
    logic [COUNT_BITS-1:0] r_stable,  n_stable;
    logic [COUNT_BITS-1:0] r_lost,    n_lost;
    logic [COORD_BITS-1:0] r_first_x, n_first_x;
    logic [COORD_BITS-1:0] r_first_y, n_first_y;
    logic [DIST_W-1:0]     r_best_d,  n_best_d;
    logic [IDX_W-1:0]      r_best_slot, n_best_slot;
    logic [COORD_BITS-1:0] r_best_x,  n_best_x;
    logic [COORD_BITS-1:0] r_best_y,  n_best_y;
    logic [SLOT_W-1:0]     r_slot,    n_slot;
    logic                  r_ovf,     n_ovf;

    // Result register
    logic                  r_out_valid;
    logic                  r_out_tv,     n_out_tv;
    logic [IDX_W-1:0]      r_out_idx,    n_out_idx;
    logic [COORD_BITS-1:0] r_out_x,      n_out_x;
    logic [COORD_BITS-1:0] r_out_y,      n_out_y;
    logic [COUNT_BITS-1:0] r_out_stable, n_out_stable;
    logic [COUNT_BITS-1:0] r_out_lost,   n_out_lost;
    logic                  r_out_ovf,    n_out_ovf;

    logic                  emits;
    logic                  load_out;
    logic                  in_range;
    logic                  upd;
    logic                  sel_gt;
    logic                  sel_lt;
    logic                  keep;
    logic [COUNT_BITS-1:0] lost_inc;
    logic [COUNT_BITS-1:0] stable_inc;
    logic [CMP_W-1:0]      d_ext;
    logic [CMP_W-1:0]      b_ext;
    logic [CMP_W-1:0]      g_ext;

    assign emits     = i_frame_empty || i_last_of_frame;
    assign o_advance = i_item_valid && (!emits || !r_out_valid || i_out_ready);
    assign load_out  = o_advance && emits;

    assign lost_inc   = (r_lost == '1) ? r_lost : r_lost + 1'b1;
    assign stable_inc = (r_stable == '1) ? r_stable : r_stable + 1'b1;
    assign in_range   = (r_slot < SLOT_W'(MAX_CANDIDATES));
    assign upd        = in_range && r_active && (i_dist_sq < r_best_d);

    // Gate compares on both possible best distances, in parallel
    assign d_ext  = CMP_W'(i_dist_sq);
    assign b_ext  = CMP_W'(r_best_d);
    assign g_ext  = CMP_W'(i_cfg.gate_sq);
    assign sel_gt = upd ? (d_ext > g_ext) : (b_ext > g_ext);
    assign sel_lt = upd ? (d_ext < g_ext) : (b_ext < g_ext);
    assign keep   = r_active && !sel_gt;

    always_comb begin
        n_active     = r_active;
        n_track_x    = r_track_x;
        n_track_y    = r_track_y;
        n_stable     = r_stable;
        n_lost       = r_lost;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_best_d     = r_best_d;
        n_best_slot  = r_best_slot;
        n_best_x     = r_best_x;
        n_best_y     = r_best_y;
        n_slot       = r_slot;
        n_ovf        = r_ovf;
        n_out_tv     = 1'b0;
        n_out_idx    = '0;
        n_out_x      = '0;
        n_out_y      = '0;
        n_out_stable = '0;
        n_out_lost   = '0;
        n_out_ovf    = 1'b0;

        if (o_advance) begin
            if (i_frame_empty) begin
                // Empty frame: count it, drop the track past the limit
                n_lost = lost_inc;
                if (LCMP_W'(lost_inc) > LCMP_W'(i_cfg.lost_limit)) begin
                    n_active = 1'b0;
                    n_stable = '0;
                end
                n_out_stable = n_stable;
                n_out_lost   = n_lost;
            end else begin
                if (in_range) begin
                    if (r_slot == '0) begin
                        n_first_x = i_cand_x;
                        n_first_y = i_cand_y;
                    end
                    if (upd) begin
                        n_best_d    = i_dist_sq;
                        n_best_slot = r_slot[IDX_W-1:0];
                        n_best_x    = i_cand_x;
                        n_best_y    = i_cand_y;
                    end
                    n_slot = r_slot + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end

                if (i_last_of_frame) begin
                    if (keep) begin
                        n_out_idx = n_best_slot;
                        n_out_x   = n_best_x;
                        n_out_y   = n_best_y;
                        n_stable  = sel_lt ? stable_inc : COUNT_BITS'(1);
                    end else begin
                        n_out_idx = '0;
                        n_out_x   = n_first_x;
                        n_out_y   = n_first_y;
                        n_stable  = COUNT_BITS'(1);
                    end
                    n_active     = 1'b1;
                    n_track_x    = n_out_x;
                    n_track_y    = n_out_y;
                    n_lost       = '0;
                    n_out_tv     = (LCMP_W'(n_stable) >= LCMP_W'(i_cfg.persist_limit));
                    n_out_stable = n_stable;
                    n_out_lost   = '0;
                    n_out_ovf    = n_ovf;
                end
            end

            // Clear the frame search after every frame end
            if (emits) begin
                n_slot      = '0;
                n_best_d    = '1;
                n_best_slot = '0;
                n_best_x    = '0;
                n_best_y    = '0;
                n_first_x   = '0;
                n_first_y   = '0;
                n_ovf       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_track_x   <= '0;
            r_track_y   <= '0;
            r_stable    <= '0;
            r_lost      <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_best_d    <= '1;
            r_best_slot <= '0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_slot      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_track_x   <= n_track_x;
            r_track_y   <= n_track_y;
            r_stable    <= n_stable;
            r_lost      <= n_lost;
            r_first_x   <= n_first_x;
            r_first_y   <= n_first_y;
            r_best_d    <= n_best_d;
            r_best_slot <= n_best_slot;
            r_best_x    <= n_best_x;
            r_best_y    <= n_best_y;
            r_slot      <= n_slot;
            r_ovf       <= n_ovf;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_tv     <= n_out_tv;
            r_out_idx    <= n_out_idx;
            r_out_x      <= n_out_x;
            r_out_y      <= n_out_y;
            r_out_stable <= n_out_stable;
            r_out_lost   <= n_out_lost;
            r_out_ovf    <= n_out_ovf;
        end
    end

    assign o_track_x       = r_track_x;
    assign o_track_y       = r_track_y;
    assign o_out_valid     = r_out_valid;
    assign o_target_valid  = r_out_tv;
    assign o_chosen_index  = r_out_idx;
    assign o_chosen_x      = r_out_x;
    assign o_chosen_y      = r_out_y;
    assign o_stable_count  = r_out_stable;
    assign o_lost_count    = r_out_lost;
    assign o_overflow_flag = r_out_ovf;

    // Without a track the stable count is zero
    a_inactive_stable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_stable == '0))
        else $error("stable count nonzero without an active track");

    // Slot counter never passes the candidate limit
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(MAX_CANDIDATES))
        else $error("slot count beyond candidate limit");

    // A fresh frame starts with no best candidate
    a_fresh_frame_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot == '0) |-> (r_best_d == '1))
        else $error("best distance not cleared at frame start");

    // A reported target always carries a nonzero stable count
    a_target_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tv) |-> (r_out_stable != '0))
        else $error("target reported with zero stable count");

    // Empty-frame results carry a lost count and no target
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_lost != '0)) |-> (!r_out_tv && (r_out_x == '0)
                                                 && !r_out_ovf))
        else $error("empty-frame result carries target data");

endmodule

>>> sv/nearest_target_tracker.sv
// nearest_target_tracker: top level of the nearest-neighbor target tracker.
// Holds the input beat register and ties together ntt_cfg, ntt_dist and ntt_core.
// Depends on ntt_pkg, ntt_cfg, ntt_dist, ntt_core.
//
// Usage:
//   Candidate beats enter on i_in_valid / o_in_ready, one candidate center per
//   beat, in score order; i_last_of_frame marks the final candidate of a frame,
//   and an empty frame is one beat with i_frame_empty set. Each frame end
//   (last or empty beat) yields exactly one result beat on o_out_valid /
//   i_out_ready; other beats yield nothing.
//   Timing: an accepted beat is held in the input beat register and processed
//   from there; a frame-end beat loads its result into the result register,
//   which offers it on o_out_valid until i_out_ready takes it.
//   Throughput: one beat per cycle, save for frame-end stalls. The per-beat work
//   is one pass of two parallel squarers, an adder and the best/gate compares
//   between the input beat register and the track state and result registers.
//   Stall: the input register keeps taking beats while a result waits; a
//   frame-end beat holds in the input register until the result register is
//   free, and o_in_ready drops only then.
//   Reset (synchronous, active low): no track, counters zero, frame search
//   cleared, registers at gate 120.0 px, persistence 3, lost limit 10.
//   Configuration goes through the APB port at byte addresses 0, 4 and 8,
//   and the user writes it only while idle; the block does not enforce this.
module nearest_target_tracker #(
    parameter int MAX_CANDIDATES = 64,
    parameter int COORD_BITS     = 16,
    parameter int COUNT_BITS     = 8,
    localparam int IDX_W         = $clog2(MAX_CANDIDATES),
    localparam int DIST_W        = 2 * COORD_BITS + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ntt_pkg::PADDR_W-1:0] paddr,
    input  logic [ntt_pkg::PDATA_W-1:0] pwdata,
    output logic [ntt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // Candidate channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [COORD_BITS-1:0]       i_cand_x,
    input  logic [COORD_BITS-1:0]       i_cand_y,
    input  logic                        i_frame_empty,
    input  logic                        i_last_of_frame,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_target_valid,
    output logic [IDX_W-1:0]            o_chosen_index,
    output logic [COORD_BITS-1:0]       o_chosen_x,
    output logic [COORD_BITS-1:0]       o_chosen_y,
    output logic [COUNT_BITS-1:0]       o_stable_count,
    output logic [COUNT_BITS-1:0]       o_lost_count,
    output logic                        o_overflow_flag
);

    ntt_pkg::t_cfg cfg;

    // Input beat register
    logic                  r_in_valid;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;
    logic                  r_in_empty;
    logic                  r_in_last;

    logic                  advance;
    logic                  in_accept;
    logic [COORD_BITS-1:0] track_x;
    logic [COORD_BITS-1:0] track_y;
    logic [DIST_W-1:0]     dist_sq;

    // Take a new beat when the register is empty or drains this cycle
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_x     <= i_cand_x;
            r_in_y     <= i_cand_y;
            r_in_empty <= i_frame_empty;
            r_in_last  <= i_last_of_frame;
        end
    end

    ntt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Distance of the buffered beat to the current track
    ntt_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_x       (r_in_x),
        .i_y       (r_in_y),
        .i_track_x (track_x),
        .i_track_y (track_y),
        .o_dist_sq (dist_sq)
    );

    ntt_core #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COORD_BITS     (COORD_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_item_valid    (r_in_valid),
        .i_cand_x        (r_in_x),
        .i_cand_y        (r_in_y),
        .i_frame_empty   (r_in_empty),
        .i_last_of_frame (r_in_last),
        .i_dist_sq       (dist_sq),
        .o_advance       (advance),
        .o_track_x       (track_x),
        .o_track_y       (track_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_target_valid  (o_target_valid),
        .o_chosen_index  (o_chosen_index),
        .o_chosen_x      (o_chosen_x),
        .o_chosen_y      (o_chosen_y),
        .o_stable_count  (o_stable_count),
        .o_lost_count    (o_lost_count),
        .o_overflow_flag (o_overflow_flag)
    );

endmodule

>>> sim/ntt_track_checker.sv
// ntt_track_checker: scoreboard for the nearest target tracker.
// Follows APB register writes and the candidate and result beats, predicts each frame report.
// Depends on ntt_pkg.
module ntt_track_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [ntt_pkg::PADDR_W-1:0] paddr,
    input  logic [ntt_pkg::PDATA_W-1:0] pwdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [15:0]                 i_cand_x,
    input  logic [15:0]                 i_cand_y,
    input  logic                        i_frame_empty,
    input  logic                        i_last_of_frame,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_target_valid,
    input  logic [5:0]                  i_chosen_index,
    input  logic [15:0]                 i_chosen_x,
    input  logic [15:0]                 i_chosen_y,
    input  logic [7:0]                  i_stable_count,
    input  logic [7:0]                  i_lost_count,
    input  logic                        i_overflow_flag,
    output int                          o_mismatches,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS = 64;

    typedef struct packed {
        logic        reported;
        logic [5:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  held;
        logic [7:0]  missed;
        logic        spilled;
    } t_frame_report;

    t_frame_report report_q[$];
    int            mismatch_n = 0;

    // register copies
    logic [ntt_pkg::GATE_W-1:0]  gate_r;
    logic [ntt_pkg::LIMIT_W-1:0] persist_r;
    logic [ntt_pkg::LIMIT_W-1:0] lost_r;

    // track and per-frame search state
    logic        trk_on;
    logic [15:0] trk_x, trk_y;
    logic [7:0]  held_n, missed_n;
    logic [15:0] head_x, head_y;
    logic [32:0] near_d;
    logic [5:0]  near_slot;
    logic [15:0] near_x, near_y;
    int          slot_n;
    logic        spilled;

    assign o_mismatches = mismatch_n;

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    task automatic clear_search();
        slot_n    = 0;
        near_d    = '1;
        near_slot = '0;
        near_x    = '0;
        near_y    = '0;
        head_x    = '0;
        head_y    = '0;
        spilled   = 1'b0;
    endtask

    // Advance the predicted track by one candidate beat; queue a report at frame end.
    task automatic track_beat(input logic [15:0] cx, input logic [15:0] cy,
                              input logic empty, input logic last);
        logic [32:0]   dx, dy, d, gate_sq;
        t_frame_report rep;
        rep = '0;
        if (empty) begin
            missed_n = bump(missed_n);
            if (missed_n > lost_r) begin
                trk_on = 1'b0;
                held_n = '0;
            end
            clear_search();
            rep.held   = held_n;
            rep.missed = missed_n;
            report_q.insert(report_q.size(), rep);
            return;
        end
        if (slot_n >= MAX_SLOTS) begin
            spilled = 1'b1;
        end else begin
            if (slot_n == 0) begin
                head_x = cx;
                head_y = cy;
            end
            if (trk_on) begin
                dx = 33'((cx >= trk_x) ? cx - trk_x : trk_x - cx);
                dy = 33'((cy >= trk_y) ? cy - trk_y : trk_y - cy);
                d  = dx * dx + dy * dy;
                if (d < near_d) begin
                    near_d    = d;
                    near_slot = 6'(slot_n);
                    near_x    = cx;
                    near_y    = cy;
                end
            end
            slot_n++;
        end
        if (!last) return;
        gate_sq = 33'(gate_r) * 33'(gate_r);
        if (trk_on && near_d > gate_sq) begin
            trk_on = 1'b0;
            held_n = '0;
        end
        if (trk_on) begin
            rep.slot = near_slot;
            rep.x    = near_x;
            rep.y    = near_y;
            held_n   = (near_d < gate_sq) ? bump(held_n) : 8'd1;
        end else begin
            rep.slot = '0;
            rep.x    = head_x;
            rep.y    = head_y;
            trk_on   = 1'b1;
            held_n   = 8'd1;
        end
        trk_x          = rep.x;
        trk_y          = rep.y;
        missed_n       = '0;
        rep.reported   = (held_n >= persist_r);
        rep.held       = held_n;
        rep.missed     = missed_n;
        rep.spilled    = spilled;
        report_q.insert(report_q.size(), rep);
        clear_search();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_n++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_report rep;
        if (!i_rst_n) begin
            gate_r    = ntt_pkg::GATE_RESET;
            persist_r = ntt_pkg::PERSIST_RESET;
            lost_r    = ntt_pkg::LOST_RESET;
            trk_on    = 1'b0;
            trk_x     = '0;
            trk_y     = '0;
            held_n    = '0;
            missed_n  = '0;
            clear_search();
            report_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ntt_pkg::PADDR_W-1:2])
                    ntt_pkg::REG_GATE:    gate_r    = pwdata[ntt_pkg::GATE_W-1:0];
                    ntt_pkg::REG_PERSIST: persist_r = pwdata[ntt_pkg::LIMIT_W-1:0];
                    ntt_pkg::REG_LOST:    lost_r    = pwdata[ntt_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    $error("result beat with no frame report waiting");
                    mismatch_n++;
                end else begin
                    rep = report_q.pop_front();
                    check_field("target_valid", 32'(rep.reported), 32'(i_target_valid));
                    check_field("chosen_index", 32'(rep.slot), 32'(i_chosen_index));
                    check_field("chosen_x", 32'(rep.x), 32'(i_chosen_x));
                    check_field("chosen_y", 32'(rep.y), 32'(i_chosen_y));
                    check_field("stable_count", 32'(rep.held), 32'(i_stable_count));
                    check_field("lost_count", 32'(rep.missed), 32'(i_lost_count));
                    check_field("overflow_flag", 32'(rep.spilled), 32'(i_overflow_flag));
                end
            end
            if (i_in_valid && i_in_ready)
                track_beat(i_cand_x, i_cand_y, i_frame_empty, i_last_of_frame);
        end
        o_pending <= report_q.size();
    end

endmodule

>>> sim/tb_top.sv
// tb_top: regression bench for nearest_target_tracker.
// Drives APB settings and candidate frames, stalls the result side, and gives the verdict.
// Depends on ntt_pkg, nearest_target_tracker and ntt_track_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEGMENTS    = 6;
    // segment that runs long single-candidate streaks to saturate both counters
    localparam int SAT_SEG     = 2;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        psel            = 1'b0;
    logic                        penable         = 1'b0;
    logic                        pwrite          = 1'b0;
    logic [ntt_pkg::PADDR_W-1:0] paddr           = '0;
    logic [ntt_pkg::PDATA_W-1:0] pwdata          = '0;
    logic [ntt_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        i_in_valid      = 1'b0;
    logic                        o_in_ready;
    logic [15:0]                 i_cand_x        = '0;
    logic [15:0]                 i_cand_y        = '0;
    logic                        i_frame_empty   = 1'b0;
    logic                        i_last_of_frame = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready     = 1'b0;
    logic                        o_target_valid;
    logic [5:0]                  o_chosen_index;
    logic [15:0]                 o_chosen_x;
    logic [15:0]                 o_chosen_y;
    logic [7:0]                  o_stable_count;
    logic [7:0]                  o_lost_count;
    logic                        o_overflow_flag;

    int          mismatch_n;
    int          pending_n;
    int          send_idle_pct  = 8;
    int          recv_stall_pct = 86;
    int          gate_now       = 1920;
    int          scene_x        = 20000;
    int          scene_y        = 20000;
    int          beats_sent     = 0;
    int unsigned cycle_n        = 0;

    nearest_target_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cand_x       (i_cand_x),
        .i_cand_y       (i_cand_y),
        .i_frame_empty  (i_frame_empty),
        .i_last_of_frame(i_last_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_target_valid (o_target_valid),
        .o_chosen_index (o_chosen_index),
        .o_chosen_x     (o_chosen_x),
        .o_chosen_y     (o_chosen_y),
        .o_stable_count (o_stable_count),
        .o_lost_count   (o_lost_count),
        .o_overflow_flag(o_overflow_flag)
    );

    ntt_track_checker track_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cand_x       (i_cand_x),
        .i_cand_y       (i_cand_y),
        .i_frame_empty  (i_frame_empty),
        .i_last_of_frame(i_last_of_frame),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_target_valid (o_target_valid),
        .i_chosen_index (o_chosen_index),
        .i_chosen_x     (o_chosen_x),
        .i_chosen_y     (o_chosen_y),
        .i_stable_count (o_stable_count),
        .i_lost_count   (o_lost_count),
        .i_overflow_flag(o_overflow_flag),
        .o_mismatches   (mismatch_n),
        .o_pending      (pending_n)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: stall at random with the current stall rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake or a lost report ends the run here.
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("nearest_target_tracker regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] clamp_coord(input int v);
        if (v < 0) return 16'h0000;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // One APB write: setup phase, access phase, then an idle phase so that
    // back-to-back writes never raise and drop psel in the same step.
    task automatic write_reg(input logic [ntt_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one candidate beat; idle the sender at random first, then hold
    // valid and payload until the beat is taken.
    task automatic send_beat(input logic [15:0] x, input logic [15:0] y,
                             input logic empty, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cand_x        <= x;
        i_cand_y        <= y;
        i_frame_empty   <= empty;
        i_last_of_frame <= last;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    // Empty frame: coordinates and last mark are noise the block must ignore.
    task automatic send_empty();
        send_beat(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1,
                  1'($urandom_range(0, 1)));
    endtask

    // Move the scene target, then send a frame of n_cand candidates with the
    // target at a random slot among clutter; now and then break off the frame
    // with an empty beat.
    task automatic send_scene_frame(input int n_cand);
        int          r, bound, step, hit, abort_at, i;
        logic [15:0] cx, cy;
        r     = $urandom_range(0, 99);
        bound = gate_now / 2 + 1;
        if (r < 15) begin
            // hold still: zero move
        end else if (r < 25 && gate_now != 65535) begin
            // move exactly the gate distance along x
            if (scene_x + gate_now <= 65535) scene_x = scene_x + gate_now;
            else scene_x = int'(clamp_coord(scene_x - gate_now));
        end else if (r < 32 && gate_now != 65535) begin
            scene_x = $urandom_range(0, 65535);
            scene_y = $urandom_range(0, 65535);
        end else begin
            step    = $urandom_range(0, 2 * bound);
            scene_x = int'(clamp_coord(scene_x + step - bound));
            step    = $urandom_range(0, 2 * bound);
            scene_y = int'(clamp_coord(scene_y + step - bound));
        end
        hit      = $urandom_range(0, n_cand - 1);
        abort_at = ($urandom_range(0, 99) < 5) ? $urandom_range(0, n_cand - 1) : -1;
        for (i = 0; i < n_cand; i++) begin
            if (i == abort_at) begin
                send_empty();
                return;
            end
            r = $urandom_range(0, 99);
            if (i == hit || r < 10) begin
                // the target itself, or a duplicate of it to force a tie
                cx = 16'(scene_x);
                cy = 16'(scene_y);
            end else if (r < 55) begin
                cx = 16'($urandom_range(0, 65535));
                cy = 16'($urandom_range(0, 65535));
            end else begin
                step = $urandom_range(0, 8 * bound);
                cx   = clamp_coord(scene_x + step - 4 * bound);
                step = $urandom_range(0, 8 * bound);
                cy   = clamp_coord(scene_y + step - 4 * bound);
            end
            send_beat(cx, cy, 1'b0, i == n_cand - 1);
        end
    endtask

    // Drop valid and hold off until every frame report has come back, then
    // let the pipeline drain before going on.
    task automatic wait_reports_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_n != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int seg, budget_end, frame_n, r;
        int g, p, l;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset register values
        // (gate 120.0 px, persistence 3, lost limit 10).
        send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);     // lone candidate opens a track
        send_beat(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);     // far candidate first ...
        send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);     // ... nearest is slot 1
        send_beat(16'd16, 16'd0, 1'b0, 1'b0);          // tie at equal distance:
        send_beat(16'd0, 16'd16, 1'b0, 1'b1);          // first wins, now reported
        send_beat(16'd1936, 16'd0, 1'b0, 1'b1);        // move exactly at gate restarts count
        send_beat(16'd40000, 16'd40000, 1'b0, 1'b0);   // all beyond gate:
        send_beat(16'd30000, 16'd30000, 1'b0, 1'b1);   // drop track, take slot 0
        send_beat(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);     // empty frame
        send_beat(16'd40000, 16'd40000, 1'b0, 1'b0);   // frame broken off
        send_beat(16'h0000, 16'h0000, 1'b1, 1'b0);     // by an empty beat
        send_beat(16'd40010, 16'd40000, 1'b0, 1'b1);   // track survives the misses
        repeat (11) send_empty();                      // run past the lost limit
        send_beat(16'd100, 16'd100, 1'b0, 1'b1);       // fresh track after loss

        // Random segments; each starts idle with a new register setting.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_reports_done();
            case (seg)
                0:       begin g = 1920;  p = 3;   l = 10;  end
                1:       begin g = 0;     p = 1;   l = 0;   end
                2:       begin g = 65535; p = 255; l = 255; end
                3:       begin g = 64;    p = 0;   l = 2;   end
                4:       begin g = 400;   p = 2;   l = 1;   end
                default: begin g = 16;    p = 4;   l = 3;   end
            endcase
            write_reg(ntt_pkg::REG_GATE, g);
            write_reg(ntt_pkg::REG_PERSIST, p);
            write_reg(ntt_pkg::REG_LOST, l);
            gate_now = g;
            case (seg / 2)
                0:       begin send_idle_pct <= 8;  recv_stall_pct <= 86; end
                1:       begin send_idle_pct <= 86; recv_stall_pct <= 8;  end
                default: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            endcase
            budget_end = beats_sent + ((seg == SAT_SEG) ? 320 : 80);
            frame_n    = 0;
            while (beats_sent < budget_end) begin
                r = $urandom_range(0, 99);
                if (frame_n == 5 && seg != SAT_SEG) begin
                    // straddle the candidate limit of 64
                    send_scene_frame($urandom_range(63, 67));
                end else if (seg == SAT_SEG) begin
                    // lone target candidates keep the track alive
                    if (r < 3) send_empty();
                    else send_scene_frame(1);
                end else if (r < 12) begin
                    repeat ($urandom_range(1, 14)) send_empty();
                end else begin
                    send_scene_frame($urandom_range(1, 6));
                end
                frame_n++;
            end
            // saturate the lost counter
            if (seg == SAT_SEG) repeat (260) send_empty();
        end

        wait_reports_done();
        if (mismatch_n == 0) begin
            $display("nearest_target_tracker regression: pass");
        end else begin
            $display("nearest_target_tracker regression: fail");
        end
        $finish;
    end

endmodule
